/* hdl/mtd_pkg.sv */
// Constants and register codes for the multi-jet trigger decision block.
package mtd_pkg;

	// Default widths of the rank fields and of the jet counters
	localparam int RANK_BITS_DEF  = 10;
	localparam int COUNT_BITS_DEF = 5;

	// Fixed field widths
	localparam int ETA_BITS       = 5;
	localparam int BX_BITS        = 3;
	localparam int MARGIN_BITS    = 6;
	localparam int NEEDED_BITS    = 5;
	localparam int CFG_INDEX_BITS = 3;

	// Full eta span in half-region units
	localparam int ETA_SPAN = 42;

	// Register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_RANK_CUT_FIRST  = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RANK_CUT_SECOND = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RANK_CUT_THIRD  = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RANK_CUT_FOURTH = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ETA_MARGIN      = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_JETS_NEEDED     = 3'd5;

	// Register reset values
	localparam int RANK_CUT_RESET   = 20;
	localparam int ETA_MARGIN_RESET = 9;
	localparam int JETS_NEEDED_RESET = 6;

	// Fixed multiplicities of the first three counters
	localparam int NEED_FIRST  = 1;
	localparam int NEED_SECOND = 2;
	localparam int NEED_THIRD  = 3;

endpackage

/* hdl/multi_jet_trigger_decision.sv */
// Multi-jet trigger decision: jet selection, threshold counters and event decision.
//
//  channel | direction | handshake          | payload
//  cand    | in        | cand_valid/stall   | jet_present .. last_of_event, one jet per item
//  dec     | out       | dec_valid/stall    | fire, one item per event on the last jet
//  cfg     | in        | cfg_valid/ready    | cfg_index, cfg_data
//
// One jet is taken every cycle while cand_stall is low; once the last jet of the event is
// accepted, its decision passes the input register and then the result register.
// Reset clears the counters, the valid flags and loads the register defaults.
// A waiting decision stalls the input only when the held jet is itself the last of an
// event; other jets keep flowing into the counters.
// Configuration writes are always taken (cfg_ready is held high).
module multi_jet_trigger_decision #(
	parameter int RANK_BITS  = mtd_pkg::RANK_BITS_DEF,
	parameter int COUNT_BITS = mtd_pkg::COUNT_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 cand_valid,
	output logic                                 cand_stall,
	input  logic                                 jet_present,
	input  logic signed [mtd_pkg::BX_BITS-1:0]   bunch_offset,
	input  logic                                 forward_flag,
	input  logic                                 tau_flag,
	input  logic [mtd_pkg::ETA_BITS-1:0]         eta_region,
	input  logic [RANK_BITS-1:0]                 jet_rank,
	input  logic                                 zero_bias,
	input  logic                                 last_of_event,

	output logic                                 dec_valid,
	input  logic                                 dec_stall,
	output logic                                 fire,

	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mtd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [RANK_BITS-1:0]                 cfg_data
);
	import mtd_pkg::*;

	localparam int CMP_BITS = (COUNT_BITS > NEEDED_BITS) ? COUNT_BITS : NEEDED_BITS;
	localparam int SUM_BITS = MARGIN_BITS + 1;

	// Configuration registers
	logic [RANK_BITS-1:0]   rank_cut_first_q;
	logic [RANK_BITS-1:0]   rank_cut_second_q;
	logic [RANK_BITS-1:0]   rank_cut_third_q;
	logic [RANK_BITS-1:0]   rank_cut_fourth_q;
	logic [MARGIN_BITS-1:0] eta_margin_q;
	logic [NEEDED_BITS-1:0] jets_needed_q;

	// Input register
	logic                   valid_s1;
	logic                   jet_present_s1;
	logic [BX_BITS-1:0]     bunch_offset_s1;
	logic                   forward_flag_s1;
	logic                   tau_flag_s1;
	logic [ETA_BITS-1:0]    eta_region_s1;
	logic [RANK_BITS-1:0]   jet_rank_s1;
	logic                   zero_bias_s1;
	logic                   last_s1;

	// Counters and result register
	logic [COUNT_BITS-1:0]  count_first_q, count_second_q, count_third_q, count_fourth_q;
	logic [COUNT_BITS-1:0]  count_first_d, count_second_d, count_third_d, count_fourth_d;
	logic                   dec_valid_q;
	logic                   fire_q;

	logic                   out_free;
	logic                   go_s1;
	logic                   take;
	logic [MARGIN_BITS-1:0] eta2;
	logic [SUM_BITS-1:0]    eta_sum;
	logic                   selected;
	logic                   fire_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_cut_first_q  <= RANK_BITS'(RANK_CUT_RESET);
			rank_cut_second_q <= RANK_BITS'(RANK_CUT_RESET);
			rank_cut_third_q  <= RANK_BITS'(RANK_CUT_RESET);
			rank_cut_fourth_q <= RANK_BITS'(RANK_CUT_RESET);
			eta_margin_q      <= MARGIN_BITS'(ETA_MARGIN_RESET);
			jets_needed_q     <= NEEDED_BITS'(JETS_NEEDED_RESET);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RANK_CUT_FIRST:  rank_cut_first_q  <= cfg_data;
				REG_RANK_CUT_SECOND: rank_cut_second_q <= cfg_data;
				REG_RANK_CUT_THIRD:  rank_cut_third_q  <= cfg_data;
				REG_RANK_CUT_FOURTH: rank_cut_fourth_q <= cfg_data;
				REG_ETA_MARGIN:      eta_margin_q      <= cfg_data[MARGIN_BITS-1:0];
				REG_JETS_NEEDED:     jets_needed_q     <= cfg_data[NEEDED_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Only a last jet needs room in the result register.
	assign out_free   = !dec_valid_q || !dec_stall;
	assign go_s1      = valid_s1 && (!last_s1 || out_free);
	assign cand_stall = valid_s1 && !go_s1;
	assign take       = cand_valid && !cand_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			jet_present_s1  <= jet_present;
			bunch_offset_s1 <= bunch_offset;
			forward_flag_s1 <= forward_flag;
			tau_flag_s1     <= tau_flag;
			eta_region_s1   <= eta_region;
			jet_rank_s1     <= jet_rank;
			zero_bias_s1    <= zero_bias;
			last_s1         <= last_of_event;
		end
	end

	// The eta window is 2*eta >= margin and 2*eta + margin <= span.
	assign eta2    = {1'b0, eta_region_s1} << 1;
	assign eta_sum = {1'b0, eta2} + {1'b0, eta_margin_q};
	assign selected = jet_present_s1 && (bunch_offset_s1 == '0) && !forward_flag_s1
		&& !tau_flag_s1 && (eta2 >= eta_margin_q) && (eta_sum <= SUM_BITS'(ETA_SPAN));

	function automatic logic [COUNT_BITS-1:0] sat_step(
		input logic [COUNT_BITS-1:0] c,
		input logic                  hit
	);
		logic [COUNT_BITS-1:0] r;
		r = c;
		if (hit && (c != '1)) begin
			r = c + COUNT_BITS'(1);
		end
		return r;
	endfunction

	always_comb begin
		count_first_d  = sat_step(count_first_q,  selected && (jet_rank_s1 >= rank_cut_first_q));
		count_second_d = sat_step(count_second_q, selected && (jet_rank_s1 >= rank_cut_second_q));
		count_third_d  = sat_step(count_third_q,  selected && (jet_rank_s1 >= rank_cut_third_q));
		count_fourth_d = sat_step(count_fourth_q, selected && (jet_rank_s1 >= rank_cut_fourth_q));
		fire_d = zero_bias_s1
			&& (count_first_d  >= COUNT_BITS'(NEED_FIRST))
			&& (count_second_d >= COUNT_BITS'(NEED_SECOND))
			&& (count_third_d  >= COUNT_BITS'(NEED_THIRD))
			&& (CMP_BITS'(count_fourth_d) >= CMP_BITS'(jets_needed_q));
	end

	// The counters restart from zero once the last jet of an event is through.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_first_q  <= '0;
			count_second_q <= '0;
			count_third_q  <= '0;
			count_fourth_q <= '0;
		end else if (go_s1) begin
			if (last_s1) begin
				count_first_q  <= '0;
				count_second_q <= '0;
				count_third_q  <= '0;
				count_fourth_q <= '0;
			end else begin
				count_first_q  <= count_first_d;
				count_second_q <= count_second_d;
				count_third_q  <= count_third_d;
				count_fourth_q <= count_fourth_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			dec_valid_q <= 1'b1;
		end else if (!dec_stall) begin
			dec_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			fire_q <= fire_d;
		end
	end

	assign dec_valid = dec_valid_q;
	assign fire      = fire_q;

endmodule
